[hw/rtl/vff_pkg.sv]
package vff_pkg;

    localparam int DEF_MAX_LINE  = 4096;
    localparam int DEF_FRAC_BITS = 16;
    localparam int LEN_W         = 13;
    localparam logic [LEN_W-1:0] LINE_LEN_RESET = 13'd64;

    localparam logic signed [63:0] CLIP_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] CLIP_LO = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [30:0] viscosity;
        logic        [30:0] conductivity;
        logic signed [31:0] grad_u_x;
        logic signed [31:0] grad_u_y;
        logic signed [31:0] grad_v_x;
        logic signed [31:0] grad_v_y;
        logic signed [31:0] grad_temp_x;
        logic signed [31:0] grad_temp_y;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
    } cell_in_t;

    typedef struct packed {
        logic signed [31:0] flux_mom_x;
        logic signed [31:0] flux_mom_y;
        logic signed [31:0] flux_energy;
        logic               saturated;
    } flux_out_t;

    // face word handed from front to back: averages and gradient combos
    typedef struct packed {
        logic signed [31:0] ua;
        logic signed [31:0] va;
        logic signed [31:0] ma;
        logic signed [31:0] ka;
        logic signed [31:0] dxx;
        logic signed [31:0] dyy;
        logic signed [31:0] sxy;
        logic signed [31:0] gtx;
        logic signed [31:0] gty;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic               sat;
    } face_word_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic               sat;
    } clip_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } back_state_t;

    function automatic clip_t clip32(input logic signed [63:0] x);
        clip_t c;
        c.sat = 1'b0;
        c.v   = x[31:0];
        if (x > CLIP_HI)
        begin
            c.sat = 1'b1;
            c.v   = 32'sh7FFF_FFFF;
        end
        else if (x < CLIP_LO)
        begin
            c.sat = 1'b1;
            c.v   = -32'sh8000_0000;
        end
        return c;
    endfunction

endpackage

[hw/rtl/vff_front.sv]
module vff_front #(
    parameter int MAX_LINE = vff_pkg::DEF_MAX_LINE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  vff_pkg::cell_in_t         in_word,
    input  logic                      cfg_wr_en,
    input  logic [vff_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                      q_full,
    output logic                      q_push,
    output vff_pkg::face_word_t       q_word
);

    localparam int POS_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
    localparam int CMP_W = ((vff_pkg::LEN_W > POS_W + 1) ? vff_pkg::LEN_W : POS_W + 1) + 1;

    logic [vff_pkg::LEN_W-1:0] line_length_reg;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [31:0]        prev_vx_reg, prev_vy_reg;
    logic [30:0]               prev_mu_reg, prev_k_reg;

    logic              accept;
    logic [CMP_W-1:0]  eff_len, len_ext, pos_inc;
    logic signed [32:0] su, sv;
    logic [31:0]        sm, sk;
    vff_pkg::clip_t     c_dxx, c_dyy, c_sxy;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && (pos_reg != '0);

    always_comb
    begin
        len_ext = CMP_W'(line_length_reg);
        if (len_ext < CMP_W'(2))
            eff_len = CMP_W'(2);
        else if (len_ext > CMP_W'(MAX_LINE))
            eff_len = CMP_W'(MAX_LINE);
        else
            eff_len = len_ext;
        pos_inc = CMP_W'(pos_reg) + CMP_W'(1);
        if (pos_inc >= eff_len)
            pos_next = '0;
        else
            pos_next = pos_inc[POS_W-1:0];
    end

    always_comb
    begin
        su = {prev_vx_reg[31], prev_vx_reg} + {in_word.vel_x[31], in_word.vel_x};
        sv = {prev_vy_reg[31], prev_vy_reg} + {in_word.vel_y[31], in_word.vel_y};
        sm = {1'b0, prev_mu_reg} + {1'b0, in_word.viscosity};
        sk = {1'b0, prev_k_reg} + {1'b0, in_word.conductivity};
        c_dxx = vff_pkg::clip32(({{32{in_word.grad_u_x[31]}}, in_word.grad_u_x} <<< 1)
                                - {{32{in_word.grad_v_y[31]}}, in_word.grad_v_y});
        c_dyy = vff_pkg::clip32(({{32{in_word.grad_v_y[31]}}, in_word.grad_v_y} <<< 1)
                                - {{32{in_word.grad_u_x[31]}}, in_word.grad_u_x});
        c_sxy = vff_pkg::clip32({{32{in_word.grad_u_y[31]}}, in_word.grad_u_y}
                                + {{32{in_word.grad_v_x[31]}}, in_word.grad_v_x});
        q_word.ua  = su[32:1];
        q_word.va  = sv[32:1];
        q_word.ma  = {1'b0, sm[31:1]};
        q_word.ka  = {1'b0, sk[31:1]};
        q_word.dxx = c_dxx.v;
        q_word.dyy = c_dyy.v;
        q_word.sxy = c_sxy.v;
        q_word.gtx = in_word.grad_temp_x;
        q_word.gty = in_word.grad_temp_y;
        q_word.nx  = in_word.normal_x;
        q_word.ny  = in_word.normal_y;
        q_word.sat = c_dxx.sat | c_dyy.sat | c_sxy.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= vff_pkg::LINE_LEN_RESET;
            pos_reg         <= '0;
            prev_vx_reg     <= '0;
            prev_vy_reg     <= '0;
            prev_mu_reg     <= '0;
            prev_k_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                line_length_reg <= cfg_wr_data;
            if (accept)
            begin
                pos_reg     <= pos_next;
                prev_vx_reg <= in_word.vel_x;
                prev_vy_reg <= in_word.vel_y;
                prev_mu_reg <= in_word.viscosity;
                prev_k_reg  <= in_word.conductivity;
            end
        end
    end

endmodule

[hw/rtl/vff_queue.sv]
module vff_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vff_pkg::face_word_t push_word,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output vff_pkg::face_word_t pop_word
);

    vff_pkg::face_word_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_word = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

[hw/rtl/vff_back.sv]
module vff_back #(
    parameter int FRAC_BITS = vff_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  vff_pkg::face_word_t q_word,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output vff_pkg::flux_out_t  out_word
);

    localparam logic signed [31:0] TWO_THIRDS =
        32'((((64'sd1) <<< (FRAC_BITS + 1)) + 64'sd1) / 64'sd3);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    vff_pkg::back_state_t state_reg, state_next;
    vff_pkg::face_word_t  w_reg;
    vff_pkg::flux_out_t   out_reg;
    logic                 out_valid_reg;
    logic [3:0]           step_reg;
    logic                 phase_reg;
    logic signed [63:0]   prod_reg;
    logic signed [33:0]   acc_reg;
    logic signed [31:0]   m23_reg, txx_reg, tyy_reg, txy_reg, phx_reg, phy_reg;
    logic signed [31:0]   fx_reg, fy_reg, fe_reg;
    logic                 flag_reg;

    logic signed [31:0]   op_a, op_b;
    logic signed [63:0]   rnd;
    vff_pkg::clip_t       r, s;
    logic signed [33:0]   r_ext;
    logic                 load_out, last;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign last      = (step_reg == 4'd15) && phase_reg;

    // operand schedule: stresses, then heat/work terms, then normal projections
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin op_a = TWO_THIRDS; op_b = w_reg.ma;  end
            4'd1:    begin op_a = m23_reg;    op_b = w_reg.dxx; end
            4'd2:    begin op_a = m23_reg;    op_b = w_reg.dyy; end
            4'd3:    begin op_a = w_reg.ma;   op_b = w_reg.sxy; end
            4'd4:    begin op_a = w_reg.ua;   op_b = txx_reg;   end
            4'd5:    begin op_a = w_reg.va;   op_b = txy_reg;   end
            4'd6:    begin op_a = w_reg.ka;   op_b = w_reg.gtx; end
            4'd7:    begin op_a = w_reg.ua;   op_b = txy_reg;   end
            4'd8:    begin op_a = w_reg.va;   op_b = tyy_reg;   end
            4'd9:    begin op_a = w_reg.ka;   op_b = w_reg.gty; end
            4'd10:   begin op_a = w_reg.nx;   op_b = txx_reg;   end
            4'd11:   begin op_a = w_reg.ny;   op_b = txy_reg;   end
            4'd12:   begin op_a = w_reg.nx;   op_b = txy_reg;   end
            4'd13:   begin op_a = w_reg.ny;   op_b = tyy_reg;   end
            4'd14:   begin op_a = w_reg.nx;   op_b = phx_reg;   end
            default: begin op_a = w_reg.ny;   op_b = phy_reg;   end
        endcase
    end

    always_comb
    begin
        rnd   = (prod_reg + RND) >>> FRAC_BITS;
        r     = vff_pkg::clip32(rnd);
        r_ext = {{2{r.v[31]}}, r.v};
        s     = vff_pkg::clip32({{30{acc_reg[33]}}, acc_reg} + {{30{r_ext[33]}}, r_ext});
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            vff_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = vff_pkg::BK_RUN;
                end
            end
            vff_pkg::BK_RUN:
            begin
                if (last)
                    state_next = vff_pkg::BK_DONE;
            end
            vff_pkg::BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = vff_pkg::BK_IDLE;
                end
            end
            default: state_next = vff_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vff_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (q_pop)
            begin
                step_reg  <= '0;
                phase_reg <= 1'b0;
            end
            else if (state_reg == vff_pkg::BK_RUN)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            w_reg    <= q_word;
            flag_reg <= q_word.sat;
        end
        else if (state_reg == vff_pkg::BK_RUN)
        begin
            if (!phase_reg)
                prod_reg <= op_a * op_b;
            else
            begin
                unique case (step_reg)
                    4'd0:  m23_reg <= r.v;
                    4'd1:  txx_reg <= r.v;
                    4'd2:  tyy_reg <= r.v;
                    4'd3:  txy_reg <= r.v;
                    4'd4, 4'd7, 4'd10, 4'd12, 4'd14: acc_reg <= r_ext;
                    4'd5, 4'd8: acc_reg <= acc_reg + r_ext;
                    4'd6:  phx_reg <= s.v;
                    4'd9:  phy_reg <= s.v;
                    4'd11: fx_reg  <= s.v;
                    4'd13: fy_reg  <= s.v;
                    default: fe_reg <= s.v;
                endcase
                priority case (step_reg)
                    4'd6, 4'd9, 4'd11, 4'd13, 4'd15: flag_reg <= flag_reg | r.sat | s.sat;
                    default: flag_reg <= flag_reg | r.sat;
                endcase
            end
        end
        if (load_out)
        begin
            out_reg.flux_mom_x  <= fx_reg;
            out_reg.flux_mom_y  <= fy_reg;
            out_reg.flux_energy <= fe_reg;
            out_reg.saturated   <= flag_reg;
        end
    end

endmodule

[hw/rtl/viscous_face_flux_2d.sv]
// channel   dir  handshake             word
// in        in   in_valid / in_stall   cell_in_t: cell velocity, mu, k, face grads, normal
// out       out  out_valid / out_stall flux_out_t: face fluxes and saturation flag
// cfg       in   cfg_wr_en             cfg_wr_data: cells per line
//
// Back end, from queue pop to output register: a pop, 16 products through one shared
// 32x32 multiplier, each multiply followed by a round/accumulate step, then a load that
// waits while a held result is stalled; it pops a new face only after loading the last.
// The front takes a cell per cycle into a 2-word queue unless it is full; the first
// cell of a line produces nothing. Reset clears line position and previous cell, sets line length to 64.
// in_stall rises only while the queue is full; out_stall holds the result in place.
module viscous_face_flux_2d #(
    parameter int MAX_LINE  = vff_pkg::DEF_MAX_LINE,
    parameter int FRAC_BITS = vff_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  vff_pkg::cell_in_t         in_word,
    output logic                      out_valid,
    input  logic                      out_stall,
    output vff_pkg::flux_out_t        out_word,
    input  logic                      cfg_wr_en,
    input  logic [vff_pkg::LEN_W-1:0] cfg_wr_data
);

    logic                q_push, q_full, q_pop, q_empty;
    vff_pkg::face_word_t q_in, q_out;

    vff_front #(.MAX_LINE(MAX_LINE)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (q_in)
    );

    vff_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_word  (q_out)
    );

    vff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_word    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

[hw/rtl/vff_checker.sv]
module vff_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input vff_pkg::flux_out_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");

    a_out_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

    a_in_reset: assert property (@(posedge clk) $rose(rst_n) |-> !in_stall)
        else $error("input stalled out of reset");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input word withdrawn");

endmodule

bind viscous_face_flux_2d vff_checker u_vff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
